>>> rtl/date_day_number_converter_unit_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef DATE_DAY_NUMBER_CONVERTER_UNIT_DEFINES_SVH
`define DATE_DAY_NUMBER_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DNC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DNC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dnc_pkg.sv
package dnc_pkg;

    typedef enum logic
    {
        ACT_TO_DAY  = 1'b0,
        ACT_TO_DATE = 1'b1
    } dnc_action_t;

    typedef struct packed
    {
        logic        action;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [22:0] day_number_in;
    } dnc_req_t;

    typedef struct packed
    {
        logic [22:0] day_number_out;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic        valid_res;
    } dnc_res_t;

    // Register stages in each conversion path.
    localparam int unsigned STAGES = 9;

    localparam logic [22:0] DN_MIN      = 23'd1721426;
    localparam logic [22:0] DN_MAX      = 23'd5373484;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [22:0] JDN_OFS     = 23'd32044;
    localparam logic [23:0] DATE_OFS    = 24'd32045;
    localparam logic [14:0] YEAR_BIAS   = 15'd4800;
    localparam logic [24:0] PERIOD_400Y = 25'd146097;
    localparam logic [17:0] PERIOD_4Y   = 18'd1461;

    // Reciprocals for division by constants.
    localparam logic [22:0] RCP_400Y = 23'((64'd1 << 40) / 64'd146097);
    localparam logic [21:0] RCP_4Y   = 22'((64'd1 << 32) / 64'd1461);
    localparam logic [12:0] RCP_153  = 13'(((64'd1 << 20) + 64'd152) / 64'd153);
    localparam logic [14:0] RCP_25   = 15'(((64'd1 << 19) + 64'd24) / 64'd25);

    // Days before the start of a month, counted from March.
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] mo, input logic leap);
        logic [4:0] r;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = leap ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/dnc_to_day.sv
module dnc_to_day
    import dnc_pkg::*;
(
    input  logic     clk,
    input  logic     adv,
    input  dnc_req_t req,
    output dnc_res_t res
);

    logic        ok1_reg, ok1_next;
    logic [14:0] y1_reg, y1_next;
    logic [3:0]  m1_reg, m1_next;
    logic [13:0] yr1_reg;
    logic [3:0]  mo1_reg;
    logic [4:0]  dy1_reg;

    logic        ok2_reg;
    logic [14:0] y2_reg;
    logic [3:0]  m2_reg;
    logic [13:0] yr2_reg;
    logic [3:0]  mo2_reg;
    logic [4:0]  dy2_reg;
    logic [7:0]  qyr2_reg, qyr2_next;
    logic [8:0]  q1002_reg, q1002_next;
    logic [6:0]  q4002_reg, q4002_next;
    logic [26:0] pyr;
    logic [27:0] p100;
    logic [25:0] p400;

    logic        ok3_reg, ok3_next;
    logic [23:0] s13_reg, s13_next;
    logic [8:0]  s23_reg, s23_next;
    logic [8:0]  q1003_reg;
    logic [13:0] rem100;
    logic [13:0] c100;
    logic        leap;

    dnc_res_t    res4_reg, res4_next;
    logic [23:0] sum4;

    dnc_res_t    dly_reg [STAGES-4];

    always_comb
    begin
        logic a;
        a = (req.month_in <= 4'd2);
        ok1_next = (req.year_in != 14'd0) && (req.year_in <= YEAR_MAX) &&
                   (req.month_in != 4'd0) && (req.month_in <= 4'd12) &&
                   (req.day_in != 5'd0);
        y1_next  = 15'(req.year_in) + YEAR_BIAS - 15'(a);
        m1_next  = a ? req.month_in + 4'd9 : req.month_in - 4'd3;
    end

    always_comb
    begin
        pyr        = 27'(yr1_reg[13:2]) * 27'(RCP_25);
        p100       = 28'(y1_reg[14:2]) * 28'(RCP_25);
        p400       = 26'(y1_reg[14:4]) * 26'(RCP_25);
        qyr2_next  = pyr[26:19];
        q1002_next = p100[27:19];
        q4002_next = p400[25:19];
    end

    always_comb
    begin
        c100      = 14'(qyr2_reg) * 14'd100;
        rem100    = yr2_reg - c100;
        leap      = (yr2_reg[1:0] == 2'd0) && ((rem100 != 14'd0) || (qyr2_reg[1:0] == 2'd0));
        ok3_next  = ok2_reg && (dy2_reg <= month_length(mo2_reg, leap));
        s13_next  = 24'(y2_reg) * 24'd365 + 24'(y2_reg[14:2]);
        s23_next  = 9'(dy2_reg) + month_offset(m2_reg) + 9'(q4002_reg);
    end

    always_comb
    begin
        sum4      = s13_reg + 24'(s23_reg) - 24'(q1003_reg) - DATE_OFS;
        res4_next = '0;
        if (ok3_reg)
        begin
            res4_next.day_number_out = sum4[22:0];
            res4_next.valid_res      = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok1_reg   <= ok1_next;
            y1_reg    <= y1_next;
            m1_reg    <= m1_next;
            yr1_reg   <= req.year_in;
            mo1_reg   <= req.month_in;
            dy1_reg   <= req.day_in;

            ok2_reg   <= ok1_reg;
            y2_reg    <= y1_reg;
            m2_reg    <= m1_reg;
            yr2_reg   <= yr1_reg;
            mo2_reg   <= mo1_reg;
            dy2_reg   <= dy1_reg;
            qyr2_reg  <= qyr2_next;
            q1002_reg <= q1002_next;
            q4002_reg <= q4002_next;

            ok3_reg   <= ok3_next;
            s13_reg   <= s13_next;
            s23_reg   <= s23_next;
            q1003_reg <= q1002_reg;

            res4_reg  <= res4_next;

            dly_reg[0] <= res4_reg;
            for (int i = 1; i < STAGES - 4; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign res = dly_reg[STAGES-5];

endmodule

>>> rtl/dnc_to_date.sv
module dnc_to_date
    import dnc_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [22:0] day_number,
    output dnc_res_t    res
);

    logic        ok1_reg, ok1_next;
    logic [24:0] x1_reg, x1_next;
    logic [22:0] a1;

    logic        ok2_reg;
    logic [24:0] x2_reg;
    logic [7:0]  q2_reg, q2_next;
    logic [47:0] p2;

    logic        ok3_reg;
    logic [7:0]  q3_reg;
    logic [24:0] r3_reg, r3_next;
    logic [25:0] t3;

    logic        ok4_reg;
    logic [7:0]  b4_reg, b4_next;
    logic [17:0] x4_reg, x4_next;
    logic        ge4;
    logic [24:0] rr4;

    logic        ok5_reg;
    logic [7:0]  b5_reg;
    logic [17:0] x5_reg;
    logic [6:0]  q5_reg, q5_next;
    logic [39:0] p5;

    logic        ok6_reg;
    logic [7:0]  b6_reg;
    logic [6:0]  q6_reg;
    logic [17:0] r6_reg, r6_next;

    logic        ok7_reg;
    logic [7:0]  b7_reg;
    logic [6:0]  d7_reg, d7_next;
    logic [8:0]  e7_reg, e7_next;
    logic [10:0] x7_reg, x7_next;
    logic        ge7;
    logic [17:0] rr7;

    logic        ok8_reg;
    logic [7:0]  b8_reg;
    logic [6:0]  d8_reg;
    logic [8:0]  e8_reg;
    logic [3:0]  m8_reg, m8_next;
    logic [23:0] p8;

    dnc_res_t    res9_reg, res9_next;
    logic        wrap;
    logic [8:0]  day9;
    logic [14:0] year9;

    always_comb
    begin
        ok1_next = (day_number >= DN_MIN) && (day_number <= DN_MAX);
        a1       = day_number + JDN_OFS;
        x1_next  = {a1, 2'b11};
    end

    always_comb
    begin
        p2      = 48'(x1_reg) * 48'(RCP_400Y);
        q2_next = p2[47:40];
    end

    always_comb
    begin
        t3      = 26'(q2_reg) * 26'(PERIOD_400Y);
        r3_next = x2_reg - t3[24:0];
    end

    always_comb
    begin
        ge4     = (r3_reg >= PERIOD_400Y);
        rr4     = ge4 ? r3_reg - PERIOD_400Y : r3_reg;
        b4_next = q3_reg + 8'(ge4);
        x4_next = {rr4[17:2], 2'b11};
    end

    always_comb
    begin
        p5      = 40'(x4_reg) * 40'(RCP_4Y);
        q5_next = p5[38:32];
    end

    always_comb
    begin
        r6_next = x5_reg - 18'(q5_reg) * PERIOD_4Y;
    end

    always_comb
    begin
        ge7     = (r6_reg >= PERIOD_4Y);
        rr7     = ge7 ? r6_reg - PERIOD_4Y : r6_reg;
        d7_next = q6_reg + 7'(ge7);
        e7_next = rr7[10:2];
        x7_next = 11'(e7_next) * 11'd5 + 11'd2;
    end

    always_comb
    begin
        p8      = 24'(x7_reg) * 24'(RCP_153);
        m8_next = p8[23:20];
    end

    always_comb
    begin
        wrap      = (m8_reg >= 4'd10);
        day9      = e8_reg - month_offset(m8_reg) + 9'd1;
        year9     = 15'(b8_reg) * 15'd100 + 15'(d8_reg) + 15'(wrap) - YEAR_BIAS;
        res9_next = '0;
        if (ok8_reg)
        begin
            res9_next.year_out  = year9[13:0];
            res9_next.month_out = wrap ? m8_reg - 4'd9 : m8_reg + 4'd3;
            res9_next.day_out   = day9[4:0];
            res9_next.valid_res = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok1_reg  <= ok1_next;
            x1_reg   <= x1_next;

            ok2_reg  <= ok1_reg;
            x2_reg   <= x1_reg;
            q2_reg   <= q2_next;

            ok3_reg  <= ok2_reg;
            q3_reg   <= q2_reg;
            r3_reg   <= r3_next;

            ok4_reg  <= ok3_reg;
            b4_reg   <= b4_next;
            x4_reg   <= x4_next;

            ok5_reg  <= ok4_reg;
            b5_reg   <= b4_reg;
            x5_reg   <= x4_reg;
            q5_reg   <= q5_next;

            ok6_reg  <= ok5_reg;
            b6_reg   <= b5_reg;
            q6_reg   <= q5_reg;
            r6_reg   <= r6_next;

            ok7_reg  <= ok6_reg;
            b7_reg   <= b6_reg;
            d7_reg   <= d7_next;
            e7_reg   <= e7_next;
            x7_reg   <= x7_next;

            ok8_reg  <= ok7_reg;
            b8_reg   <= b7_reg;
            d8_reg   <= d7_reg;
            e8_reg   <= e7_reg;
            m8_reg   <= m8_next;

            res9_reg <= res9_next;
        end
    end

    assign res = res9_reg;

endmodule

>>> rtl/date_day_number_converter_unit.sv
// Gregorian date and Julian day number converter.
// A request transaction on req carries an action and its operands: action
// ACT_TO_DAY checks year_in, month_in and day_in and returns the day number,
// action ACT_TO_DATE checks day_number_in and returns year, month and day.
// Each request produces exactly one result transaction on res, in order.
// A rejected request returns a result with every field zero.
// The datapath is a ten-stage pipeline: nine stages of arithmetic, set by
// the chain of reciprocal multiplies and remainder corrections on the day
// number path, followed by the output register. One request is taken every
// cycle while req_stall is low.
// Valid bits move with the data. When the receiver holds res_stall while a
// result is waiting, the whole pipeline freezes and req_stall rises in the
// same cycle, so nothing is dropped or repeated. Bubbles are held too.
// Reset clears all valid bits; the pipeline is empty and ready afterward.
`include "date_day_number_converter_unit_defines.svh"

module date_day_number_converter_unit
    import dnc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  dnc_req_t req,
    output logic     res_valid,
    input  logic     res_stall,
    output dnc_res_t res
);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] act_reg;
    logic              out_vld_reg;
    dnc_res_t          res_reg, res_next;
    dnc_res_t          day_res;
    dnc_res_t          date_res;
    logic              adv;

    logic              res_ok;
    logic              res_bad;
    logic              date_zero;
    logic              all_zero;
    logic              day_set;
    logic              date_set;
    logic              date_ok;
    logic [STAGES:0]   pipe_vld;

    assign req_stall = out_vld_reg && res_stall;
    assign adv       = !req_stall;

    dnc_to_day u_to_day
    (
        .clk (clk),
        .adv (adv),
        .req (req),
        .res (day_res)
    );

    dnc_to_date u_to_date
    (
        .clk        (clk),
        .adv        (adv),
        .day_number (req.day_number_in),
        .res        (date_res)
    );

    always_comb
    begin
        res_next = (act_reg[STAGES-1] == ACT_TO_DATE) ? date_res : day_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[STAGES-2:0], req_valid};
            out_vld_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act_reg <= {act_reg[STAGES-2:0], req.action};
            res_reg <= res_next;
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = res_reg;

    assign res_ok    = res_valid && res.valid_res;
    assign res_bad   = res_valid && !res.valid_res;
    assign date_zero = (res.year_out == 14'd0) && (res.month_out == 4'd0) &&
                       (res.day_out == 5'd0);
    assign all_zero  = date_zero && (res.day_number_out == 23'd0);
    assign day_set   = res_ok && (res.day_number_out != 23'd0);
    assign date_set  = res_ok && (res.year_out != 14'd0);
    assign date_ok   = (res.month_out >= 4'd1) && (res.month_out <= 4'd12) &&
                       (res.day_out != 5'd0);
    assign pipe_vld  = {vld_reg, out_vld_reg};

    `DNC_ASSERT_IMPL(a_reject_zero, res_bad, all_zero, "rejected result is not all zero")
    `DNC_ASSERT_IMPL(a_day_only, day_set, date_zero, "day number result carries a date")
    `DNC_ASSERT_IMPL(a_date_range, date_set, date_ok, "converted date out of range")
    `DNC_ASSERT_NEXT(a_freeze, req_stall, $stable(pipe_vld), "pipeline moved while stalled")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dnc_pkg::*;

    class conversion_scoreboard;
        dnc_res_t awaited_results[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function bit is_leap(input int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        function int unsigned days_in(input int unsigned mo, input int unsigned y);
            int unsigned n;
            case (mo)
                1, 3, 5, 7, 8, 10, 12: n = 31;
                4, 6, 9, 11:           n = 30;
                2:                     n = is_leap(y) ? 29 : 28;
                default:               n = 0;
            endcase
            return n;
        endfunction

        function dnc_res_t convert(input dnc_req_t r);
            dnc_res_t    o;
            int unsigned yr, mo, dy, jdn;
            int unsigned a, y, m, b, c, d, e, n;
            o   = '0;
            yr  = r.year_in;
            mo  = r.month_in;
            dy  = r.day_in;
            jdn = r.day_number_in;
            if (dnc_action_t'(r.action) == ACT_TO_DAY)
            begin
                if (yr >= 1 && yr <= YEAR_MAX && dy >= 1 && dy <= days_in(mo, yr))
                begin
                    a = (mo <= 2) ? 1 : 0;
                    y = yr + 4800 - a;
                    m = mo + 12 * a - 3;
                    n = dy + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
                    o.day_number_out = 23'(n);
                    o.valid_res      = 1'b1;
                end
            end
            else if (jdn >= DN_MIN && jdn <= DN_MAX)
            begin
                a = jdn + 32044;
                b = (4 * a + 3) / 146097;
                c = a - (146097 * b) / 4;
                d = (4 * c + 3) / 1461;
                e = c - (1461 * d) / 4;
                m = (5 * e + 2) / 153;
                o.day_out   = 5'(e - (153 * m + 2) / 5 + 1);
                o.month_out = 4'(m + 3 - 12 * (m / 10));
                o.year_out  = 14'(100 * b + d - 4800 + m / 10);
                o.valid_res = 1'b1;
            end
            return o;
        endfunction

        function void note_request(input dnc_req_t r);
            awaited_results.push_back(convert(r));
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        task check_result(input dnc_res_t got);
            dnc_res_t want;
            if (awaited_results.size() == 0)
            begin
                report("result transaction with no request outstanding");
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.day_number_out !== want.day_number_out)
                    report($sformatf("day_number_out %0d, expected %0d",
                                     got.day_number_out, want.day_number_out));
                if (got.year_out !== want.year_out)
                    report($sformatf("year_out %0d, expected %0d", got.year_out, want.year_out));
                if (got.month_out !== want.month_out)
                    report($sformatf("month_out %0d, expected %0d",
                                     got.month_out, want.month_out));
                if (got.day_out !== want.day_out)
                    report($sformatf("day_out %0d, expected %0d", got.day_out, want.day_out));
                if (got.valid_res !== want.valid_res)
                    report($sformatf("valid_res %0b, expected %0b",
                                     got.valid_res, want.valid_res));
            end
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    dnc_req_t req;
    logic     res_valid;
    logic     res_stall;
    dnc_res_t res;
    bit       calm;

    conversion_scoreboard sb;

    date_day_number_converter_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL date_day_number_converter_unit");
        $finish;
    end

    always @(negedge clk)
    begin
        res_stall <= rst_n && !calm && ($urandom_range(0, 99) < 9);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
    end

    function automatic dnc_req_t make_date(input int unsigned y, input int unsigned m,
                                           input int unsigned d);
        dnc_req_t r;
        r.action        = ACT_TO_DAY;
        r.year_in       = 14'(y);
        r.month_in      = 4'(m);
        r.day_in        = 5'(d);
        r.day_number_in = 23'($urandom);
        return r;
    endfunction

    function automatic dnc_req_t make_day_number(input int unsigned n);
        dnc_req_t r;
        r.action        = ACT_TO_DATE;
        r.year_in       = 14'($urandom);
        r.month_in      = 4'($urandom);
        r.day_in        = 5'($urandom);
        r.day_number_in = 23'(n);
        return r;
    endfunction

    function automatic dnc_req_t random_request();
        int unsigned kind, y, m;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            if ($urandom_range(0, 9) == 0)
                y = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 5) : $urandom_range(9995, 9999);
            else
                y = $urandom_range(1, 9999);
            m = $urandom_range(1, 12);
            return make_date(y, m, $urandom_range(1, sb.days_in(m, y)));
        end
        else if (kind < 80)
        begin
            case ($urandom_range(0, 9))
                0:       return make_day_number($urandom_range(DN_MIN, DN_MIN + 800));
                1:       return make_day_number($urandom_range(DN_MAX - 800, DN_MAX));
                default: return make_day_number($urandom_range(DN_MIN, DN_MAX));
            endcase
        end
        else if (kind < 90)
        begin
            return make_date($urandom, $urandom, $urandom);
        end
        else
        begin
            return make_day_number($urandom);
        end
    endfunction

    task send_request(input dnc_req_t r);
        if (!calm && $urandom_range(0, 99) < 9)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task drain_results();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        calm      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(make_date(1, 1, 1));
        send_request(make_date(9999, 12, 31));
        send_request(make_date(0, 1, 1));
        send_request(make_date(10000, 1, 1));
        send_request(make_date(16383, 15, 31));
        send_request(make_date(2000, 2, 29));
        send_request(make_date(1900, 2, 29));
        send_request(make_date(2024, 2, 29));
        send_request(make_date(2023, 2, 29));
        send_request(make_date(2023, 2, 28));
        send_request(make_date(2023, 4, 31));
        send_request(make_date(2023, 4, 30));
        send_request(make_date(2023, 0, 10));
        send_request(make_date(2023, 13, 10));
        send_request(make_date(2023, 5, 0));
        send_request(make_date(1582, 10, 15));
        send_request(make_day_number(DN_MIN));
        send_request(make_day_number(DN_MIN - 1));
        send_request(make_day_number(DN_MAX));
        send_request(make_day_number(DN_MAX + 1));
        send_request(make_day_number(0));
        send_request(make_day_number(23'h7FFFFF));
        send_request(make_day_number(2451545));
        send_request(make_day_number(2460000));
        drain_results();

        for (int i = 0; i < 1950; i++)
        begin
            calm = (i >= 900 && i < 1200);
            if (i == 1500)
                drain_results();
            send_request(random_request());
        end
        calm = 1'b0;

        drain_results();
        repeat (3 * STAGES) @(negedge clk);
        if (sb.errors == 0)
            $display("PASS date_day_number_converter_unit");
        else
            $display("FAIL date_day_number_converter_unit");
        $finish;
    end
endmodule
